// ----- rtl/falu_pkg.sv -----
// falu_pkg: opcodes, defaults and the control word that runs down the alu pipeline
// no dependencies
package falu_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DATA_W        = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_LT       = 4'd4,
    OP_GT       = 4'd5,
    OP_LE       = 4'd6,
    OP_GE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_t;

  // control and finished results traveling with each word
  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              neg;
    logic              cmp;
    logic              dz;
    logic [DATA_W-1:0] value;
  } ctl_t;

endpackage

// ----- rtl/falu_front.sv -----
// falu_front: input stage, evaluates all non-divide opcodes and loads the divider chain
// depends on falu_pkg
module falu_front
  import falu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DVD_W     = DATA_W + FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     in_valid,
  input  logic [3:0]               op,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  output ctl_t                     ctl,
  output logic [DVD_W-1:0]         dvd,
  output logic [DATA_W-1:0]        dvs
);

  ctl_t                     ctl_next;
  logic [DVD_W-1:0]         dvd_next;
  logic [DATA_W-1:0]        a_mag;
  logic [DATA_W-1:0]        b_mag;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic                     lt;
  logic                     gt;

  // magnitudes, compares, product and dividend
  always_comb begin
    a_mag   = operand_a[DATA_W-1] ? DATA_W'(-operand_a) : DATA_W'(operand_a);
    b_mag   = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : DATA_W'(operand_b);
    lt      = operand_a < operand_b;
    gt      = operand_a > operand_b;
    prod    = (2*DATA_W)'(operand_a) * (2*DATA_W)'(operand_b);
    prod_sh = prod >>> FRAC_BITS;
    dvd_next = {a_mag, {FRAC_BITS{1'b0}}};
  end

  // opcode decode
  always_comb begin
    ctl_next        = '0;
    ctl_next.valid  = in_valid;
    case (op_t'(op))
      OP_ADD:      ctl_next.value = operand_a + operand_b;
      OP_SUB:      ctl_next.value = operand_a - operand_b;
      OP_MUL:      ctl_next.value = prod_sh[DATA_W-1:0];
      OP_DIV: begin
        if (operand_b == '0) begin
          ctl_next.dz = 1'b1;
        end else begin
          ctl_next.is_div = 1'b1;
          ctl_next.neg    = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
        end
      end
      OP_LT:       ctl_next.cmp = lt;
      OP_GT:       ctl_next.cmp = gt;
      OP_LE:       ctl_next.cmp = !gt;
      OP_GE:       ctl_next.cmp = !lt;
      OP_EQ:       ctl_next.cmp = operand_a == operand_b;
      OP_NE:       ctl_next.cmp = operand_a != operand_b;
      OP_MIN:      ctl_next.value = lt ? operand_a : operand_b;
      OP_MAX:      ctl_next.value = gt ? operand_a : operand_b;
      OP_INC:      ctl_next.value = operand_a + DATA_W'(1);
      OP_DEC:      ctl_next.value = operand_a - DATA_W'(1);
      OP_TO_INT:   ctl_next.value = operand_a >>> FRAC_BITS;
      OP_FROM_INT: ctl_next.value = operand_a << FRAC_BITS;
      default:     ctl_next.value = '0;
    endcase
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (advance) begin
      ctl.valid <= ctl_next.valid;
    end
    if (advance) begin
      ctl.is_div <= ctl_next.is_div;
      ctl.neg    <= ctl_next.neg;
      ctl.cmp    <= ctl_next.cmp;
      ctl.dz     <= ctl_next.dz;
      ctl.value  <= ctl_next.value;
      dvd        <= dvd_next;
      dvs        <= b_mag;
    end
  end

endmodule

// ----- rtl/falu_div_cell.sv -----
// falu_div_cell: one restoring divide step, one quotient bit per cell
// depends on falu_pkg
module falu_div_cell
  import falu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DVD_W     = DATA_W + FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  ctl_t              ctl_in,
  input  logic [DATA_W-1:0] rem_in,
  input  logic [DVD_W-1:0]  dvd_in,
  input  logic [DATA_W-1:0] dvs_in,
  input  logic [DATA_W-1:0] quo_in,
  output ctl_t              ctl_out,
  output logic [DATA_W-1:0] rem_out,
  output logic [DVD_W-1:0]  dvd_out,
  output logic [DATA_W-1:0] dvs_out,
  output logic [DATA_W-1:0] quo_out
);

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              qbit;
  logic [DATA_W-1:0] rem_next;

  // shift in next dividend bit and try subtracting
  always_comb begin
    trial    = {rem_in, dvd_in[DVD_W-1]};
    diff     = trial - {1'b0, dvs_in};
    qbit     = trial >= {1'b0, dvs_in};
    rem_next = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (advance) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (advance) begin
      ctl_out.is_div <= ctl_in.is_div;
      ctl_out.neg    <= ctl_in.neg;
      ctl_out.cmp    <= ctl_in.cmp;
      ctl_out.dz     <= ctl_in.dz;
      ctl_out.value  <= ctl_in.value;
      rem_out        <= rem_next;
      dvd_out        <= {dvd_in[DVD_W-2:0], 1'b0};
      dvs_out        <= dvs_in;
      quo_out        <= {quo_in[DATA_W-2:0], qbit};
    end
  end

endmodule

// ----- rtl/fixed_point_alu_unit.sv -----
// fixed_point_alu_unit: top level, front stage, divider cell chain and output register
// depends on falu_pkg, falu_front, falu_div_cell
//
// Signed 32-bit fixed-point alu with FRAC_BITS fraction bits. It takes one word per
// cycle while in_stall is low and returns one result word per input word, in order.
// Every word runs through the same pipeline from acceptance to out_valid: one front
// stage that evaluates all opcodes except divide, then a chain of 32 + FRAC_BITS
// restoring divider cells, one quotient bit per cell, then the output register. The
// whole pipeline holds while out_stall keeps a result waiting, and in_stall follows
// that.
module fixed_point_alu_unit
  import falu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               op,
  input  logic signed [DATA_W-1:0] operand_a,
  input  logic signed [DATA_W-1:0] operand_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] value,
  output logic                     compare_true,
  output logic                     div_zero
);

  localparam int DVD_W  = DATA_W + FRAC_BITS;
  localparam int CELLS  = DVD_W;

  logic advance;
  ctl_t              ctl [CELLS+1];
  logic [DATA_W-1:0] rem [CELLS+1];
  logic [DVD_W-1:0]  dvd [CELLS+1];
  logic [DATA_W-1:0] dvs [CELLS+1];
  logic [DATA_W-1:0] quo [CELLS+1];
  logic [DATA_W-1:0] value_next;

  // pipeline moves unless a result is held
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  falu_front #(.FRAC_BITS(FRAC_BITS), .DVD_W(DVD_W)) u_front (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(in_valid), .op(op),
    .operand_a(operand_a), .operand_b(operand_b),
    .ctl(ctl[0]), .dvd(dvd[0]), .dvs(dvs[0])
  );
  assign rem[0] = '0;
  assign quo[0] = '0;

  // divider chain
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    falu_div_cell #(.FRAC_BITS(FRAC_BITS), .DVD_W(DVD_W)) u_cell (
      .clk(clk), .rst(rst), .advance(advance),
      .ctl_in(ctl[i]), .rem_in(rem[i]), .dvd_in(dvd[i]), .dvs_in(dvs[i]),
      .quo_in(quo[i]),
      .ctl_out(ctl[i+1]), .rem_out(rem[i+1]), .dvd_out(dvd[i+1]),
      .dvs_out(dvs[i+1]), .quo_out(quo[i+1])
    );
  end

  // quotient sign fixup
  always_comb begin
    if (ctl[CELLS].is_div) begin
      value_next = ctl[CELLS].neg ? DATA_W'(-quo[CELLS]) : quo[CELLS];
    end else begin
      value_next = ctl[CELLS].value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ctl[CELLS].valid;
    end
    if (advance) begin
      value        <= value_next;
      compare_true <= ctl[CELLS].cmp;
      div_zero     <= ctl[CELLS].dz;
    end
  end

endmodule

// ----- rtl/falu_checker.sv -----
// falu_checker: port-level assertions for the fixed-point alu
// depends on fixed_point_alu_unit ports; bound below
module falu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] value,
  input logic        compare_true,
  input logic        div_zero
);

  // a held result word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // divide by zero gives zero value
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> value == '0)
    else $error("divide by zero with nonzero value");

  // compare results carry zero value
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> value == '0)
    else $error("compare result with nonzero value");

  // flags are exclusive
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(compare_true && div_zero))
    else $error("compare and divide-by-zero both set");

endmodule

bind fixed_point_alu_unit falu_checker u_falu_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .value(value), .compare_true(compare_true), .div_zero(div_zero)
);

// ----- tb/fixed_point_alu_unit_tb.sv -----
// fixed_point_alu_unit_tb: self-checking bench for the fixed-point alu pipeline
// depends on falu_pkg and fixed_point_alu_unit
`timescale 1ns / 1ps

module fixed_point_alu_unit_tb
  import falu_pkg::*;
();

  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic signed [31:0] value;
    logic               compare_true;
    logic               div_zero;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] op = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] value;
  logic compare_true;
  logic div_zero;

  alu_res_t result_fifo[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  fixed_point_alu_unit #(.FRAC_BITS(FB)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .compare_true(compare_true), .div_zero(div_zero)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predicted result of one word
  function automatic alu_res_t alu_predict(op_t o, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_res_t r;
    logic signed [63:0] wide;
    r.value = '0;
    r.compare_true = 1'b0;
    r.div_zero = 1'b0;
    case (o)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        wide = 64'(a) * 64'(b);
        r.value = 32'(wide >>> FB);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.div_zero = 1'b1;
        end else begin
          wide = 64'(a) <<< FB;
          r.value = 32'(wide / 64'(b));
        end
      end
      OP_LT: r.compare_true = a < b;
      OP_GT: r.compare_true = a > b;
      OP_LE: r.compare_true = a <= b;
      OP_GE: r.compare_true = a >= b;
      OP_EQ: r.compare_true = a == b;
      OP_NE: r.compare_true = a != b;
      OP_MIN: r.value = (a < b) ? a : b;
      OP_MAX: r.value = (a > b) ? a : b;
      OP_INC: r.value = a + 1;
      OP_DEC: r.value = a - 1;
      OP_TO_INT: r.value = a >>> FB;
      default: r.value = a << FB;
    endcase
    return r;
  endfunction

  // send one word, idling at random first
  task automatic send_word(op_t o, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    operand_a <= a;
    operand_b <= b;
    result_fifo.push_back(alu_predict(o, a, b));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stall and result check
  always @(posedge clk) begin
    alu_res_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (result_fifo.size() == 0) begin
          $error("result with no expectation: value %0d", value);
          errors++;
        end else begin
          exp_r = result_fifo.pop_front();
          if (value !== exp_r.value) begin
            $error("value expected %0d actual %0d", exp_r.value, value);
            errors++;
          end
          if (compare_true !== exp_r.compare_true) begin
            $error("compare_true expected %0b actual %0b", exp_r.compare_true,
                   compare_true);
            errors++;
          end
          if (div_zero !== exp_r.div_zero) begin
            $error("div_zero expected %0b actual %0b", exp_r.div_zero, div_zero);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'($signed($urandom_range(511)) - 256);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      3: return 32'($signed($urandom_range(65535)) - 32768) <<< FB;
      default: return $urandom;
    endcase
  endfunction

  // extremes and special cases for every opcode
  task automatic test_directed();
    logic [31:0] corner[6];
    corner = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h100, 32'hFFFF_FF00};
    for (int o = 0; o < 16; o++)
      send_word(op_t'(o), corner[o % 6], corner[(o + 2) % 6]);
    send_word(OP_DIV, 32'h7FFF_FFFF, 32'h0);
    send_word(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_DIV, 32'hFFFF_FD00, 32'h200);
    send_word(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_EQ, 32'h1234_5678, 32'h1234_5678);
    send_word(OP_TO_INT, 32'hFFFF_FFFF, 32'h5555_5555);
    send_word(OP_FROM_INT, 32'h0080_0001, 32'hAAAA_AAAA);
    go_idle();
  endtask

  // random words under one idling and receiver stall pattern
  task automatic test_random(int n, int idle_pct, int stall_pct);
    op_t o;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      o = op_t'($urandom_range(15));
      send_word(o, rand_operand(), ($urandom_range(19) == 0) ? 32'h0 : rand_operand());
    end
    go_idle();
  endtask

  task automatic drain();
    while (result_fifo.size() != 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (FB + 40) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(250, 88, 0);
    test_random(250, 0, 88);
    test_random(300, 25, 25);
    drain();
    if (errors == 0) begin
      $display("fixed_point_alu_unit_tb passed");
    end else begin
      $display("fixed_point_alu_unit_tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("fixed_point_alu_unit_tb failed");
    $finish;
  end

endmodule

// ----- fixed_point_alu_unit.f -----
rtl/falu_pkg.sv
rtl/falu_front.sv
rtl/falu_div_cell.sv
rtl/fixed_point_alu_unit.sv
rtl/falu_checker.sv
tb/fixed_point_alu_unit_tb.sv
